// ----- hdl/pdse_pkg.sv -----
// pdse_pkg: shared types, constants and helpers for the positional dictionary
// string encoder. No dependencies.
package pdse_pkg;

  localparam int MAX_POS = 48;
  localparam int BYTES   = 256;
  localparam int ENTRIES = MAX_POS * BYTES;
  localparam int POS_W   = 6;
  localparam int ADDR_W  = 14;
  localparam int KEY_W   = 63;
  localparam int WID_W   = 4;
  localparam int REM_W   = 10;

  localparam logic [7:0] CODE_ILLEGAL = 8'd255;
  localparam logic [7:0] BYTE_LAST    = 8'd255;

  localparam logic [2:0] REQ_ADD_CHAR = 3'd0;
  localparam logic [2:0] REQ_ADD_LEN  = 3'd1;
  localparam logic [2:0] REQ_BUILD    = 3'd2;
  localparam logic [2:0] REQ_ENC_CHAR = 3'd3;
  localparam logic [2:0] REQ_ENC_END  = 3'd4;
  localparam logic [2:0] REQ_DECODE   = 3'd5;

  typedef struct packed {
    logic             status;
    logic [KEY_W-1:0] key_out;
    logic             key_null;
    logic [5:0]       total_bits;
    logic [KEY_W-1:0] largest_code;
    logic [7:0]       decoded_char;
    logic [5:0]       decoded_length;
    logic             last_of_run;
    logic             stats_valid;
  } res_t;

  // bit length of a byte
  function automatic logic [WID_W-1:0] bitlen8(input logic [7:0] x);
    logic [WID_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) n = WID_W'(i + 1);
    end
    return n;
  endfunction

  // all ones of a field width
  function automatic logic [8:0] ones_mask(input logic [WID_W-1:0] w);
    return (9'd1 << w) - 9'd1;
  endfunction

endpackage

// ----- hdl/pdse_outreg.sv -----
// pdse_outreg: result holding register between the sequencer and the output
// channel. Depends on pdse_pkg.
module pdse_outreg
  import pdse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic free,
  output logic out_valid,
  input  logic out_stall,
  output res_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dout <= din;
    end
  end

  assign free = !out_valid || !out_stall;

endmodule

// ----- hdl/pdse_core.sv -----
// pdse_core: request sequencer with the symbol/code, character and width
// memories. Depends on pdse_pkg.
module pdse_core
  import pdse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic [5:0]       position,
  input  logic [7:0]       char_value,
  input  logic             option_flag,
  input  logic [KEY_W-1:0] code_in,
  input  logic             out_free,
  output logic             push,
  output res_t             res_out
);

  typedef enum logic [26:0] {
    S_CLEAR   = 27'd1 << 0,
    S_IDLE    = 27'd1 << 1,
    S_DISP    = 27'd1 << 2,
    S_ADD_RD  = 27'd1 << 3,
    S_ADD_WR  = 27'd1 << 4,
    S_B_POS   = 27'd1 << 5,
    S_B_RD    = 27'd1 << 6,
    S_B_CHK   = 27'd1 << 7,
    S_B_END   = 27'd1 << 8,
    S_EC_RD   = 27'd1 << 9,
    S_EC_DO   = 27'd1 << 10,
    S_EE_RD   = 27'd1 << 11,
    S_EE_T    = 27'd1 << 12,
    S_EE_LRD  = 27'd1 << 13,
    S_EE_LDO  = 27'd1 << 14,
    S_F_POS   = 27'd1 << 15,
    S_F_ZERO  = 27'd1 << 16,
    S_F_RD    = 27'd1 << 17,
    S_F_WR    = 27'd1 << 18,
    S_D1_INIT = 27'd1 << 19,
    S_D1_RD   = 27'd1 << 20,
    S_D1_CC   = 27'd1 << 21,
    S_D1_CH   = 27'd1 << 22,
    S_D2_RD   = 27'd1 << 23,
    S_D2_CC   = 27'd1 << 24,
    S_D2_CH   = 27'd1 << 25,
    S_OUT     = 27'd1 << 26
  } state_t;

  state_t state;

  // memories: {seen, code} per entry, decode characters, field widths
  logic [8:0]       sc_mem   [ENTRIES];
  logic [7:0]       char_mem [ENTRIES];
  logic [WID_W-1:0] wid_mem  [MAX_POS];

  logic [ADDR_W-1:0] sc_addr, char_addr;
  logic [POS_W-1:0]  wid_addr;
  logic              sc_we, char_we, wid_we;
  logic [8:0]        sc_wdata;
  logic [7:0]        char_wdata;
  logic [WID_W-1:0]  wid_wdata;
  logic [8:0]        sc_q;
  logic [7:0]        char_q;
  logic [WID_W-1:0]  wid_q;

  // latched request
  logic [2:0]       req;
  logic [POS_W-1:0] pos;
  logic [7:0]       ch;
  logic             opt;
  logic [KEY_W-1:0] code;

  // architectural state
  logic [POS_W-1:0] longest;
  logic             valid_flag;
  logic             dec;
  logic [KEY_W-1:0] acc;
  logic             enc_failed;
  logic [KEY_W-1:0] pmc;

  // working registers
  logic [ADDR_W-1:0] clr;
  logic [POS_W-1:0]  ipos;
  logic [7:0]        ibyte;
  logic [7:0]        cnt;
  logic [6:0]        total;
  logic [POS_W-1:0]  len;
  logic [REM_W-1:0]  wsum;
  logic [REM_W-1:0]  rem;
  logic [KEY_W-1:0]  shreg;
  res_t              res;

  logic [8:0]        w_ones;
  logic [8:0]        ec_cc;
  logic              ec_f;
  logic [7:0]        b_cm1;
  logic [WID_W-1:0]  b_w;
  logic [KEY_W-1:0]  b_pmc;
  logic [6:0]        b_total;
  logic [7:0]        d1_cc;
  logic [REM_W-1:0]  d2_remn;
  logic [KEY_W-1:0]  d2_sh;
  logic [7:0]        d2_cc;

  // datapath terms
  always_comb begin
    w_ones = ones_mask(wid_q);
    ec_f   = 1'b0;
    if (ch == 8'd0) begin
      ec_cc = 9'd0;
    end else if (ch == BYTE_LAST && sc_q[7:0] == CODE_ILLEGAL) begin
      ec_cc = w_ones;
    end else begin
      ec_cc = {1'b0, sc_q[7:0]};
      ec_f  = (sc_q[7:0] == CODE_ILLEGAL);
    end
    b_cm1   = cnt - 8'd1;
    b_w     = (cnt > 8'd1) ? bitlen8(b_cm1) : '0;
    b_pmc   = (!opt && b_w != '0) ? (pmc << b_w) + KEY_W'(b_cm1) : pmc;
    b_total = total + 7'(b_w);
    d1_cc   = shreg[7:0] & w_ones[7:0];
    d2_remn = rem - REM_W'(wid_q);
    d2_sh   = (d2_remn >= REM_W'(KEY_W)) ? '0 : (code >> d2_remn[5:0]);
    d2_cc   = d2_sh[7:0] & w_ones[7:0];
  end

  // memory port control
  always_comb begin
    sc_addr    = {pos, ch};
    sc_we      = 1'b0;
    sc_wdata   = {1'b1, sc_q[7:0]};
    char_addr  = {ipos, ibyte};
    char_we    = 1'b0;
    char_wdata = 8'd0;
    wid_addr   = ipos;
    wid_we     = 1'b0;
    wid_wdata  = '0;
    case (state)
      S_CLEAR: begin
        sc_addr  = clr;
        sc_we    = 1'b1;
        sc_wdata = {1'b0, CODE_ILLEGAL};
        wid_addr = clr[POS_W-1:0];
        wid_we   = (clr < ADDR_W'(MAX_POS));
      end
      S_ADD_RD: sc_addr = {pos, (req == REQ_ADD_CHAR) ? ch : 8'd0};
      S_ADD_WR: begin
        sc_addr = {pos, (req == REQ_ADD_CHAR) ? ch : 8'd0};
        sc_we   = 1'b1;
      end
      S_B_RD: sc_addr = {ipos, ibyte};
      S_B_CHK: begin
        sc_addr  = {ipos, ibyte};
        sc_we    = sc_q[8] && !opt;
        sc_wdata = {1'b1, cnt};
        wid_we   = sc_q[8] && cnt == 8'd255 && !opt;
      end
      S_B_END: begin
        wid_we    = !opt;
        wid_wdata = b_w;
      end
      S_EC_RD: wid_addr = pos;
      S_EE_RD: begin
        sc_addr  = {pos, 8'd0};
        wid_addr = pos;
      end
      S_F_ZERO: char_we = 1'b1;
      S_F_RD:   sc_addr = {ipos, ibyte};
      S_F_WR: begin
        char_addr  = {ipos, sc_q[7:0]};
        char_we    = (sc_q[7:0] != CODE_ILLEGAL);
        char_wdata = ibyte;
      end
      S_D1_CC: char_addr = {ipos, d1_cc};
      S_D2_CC: char_addr = {ipos, d2_cc};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_addr] <= sc_wdata;
    end
    if (sc_addr < ADDR_W'(ENTRIES)) begin
      sc_q <= sc_mem[sc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_addr] <= char_wdata;
    end
    if (char_addr < ADDR_W'(ENTRIES)) begin
      char_q <= char_mem[char_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wid_we) begin
      wid_mem[wid_addr] <= wid_wdata;
    end
    if (wid_addr < POS_W'(MAX_POS)) begin
      wid_q <= wid_mem[wid_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      longest    <= '0;
      valid_flag <= 1'b1;
      dec        <= 1'b0;
      acc        <= '0;
      enc_failed <= 1'b0;
      pmc        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == ADDR_W'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= req_type;
            pos   <= position;
            ch    <= char_value;
            opt   <= option_flag;
            code  <= code_in;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res <= '0;
          case (req)
            REQ_ADD_CHAR: begin
              if (!dec && pos < POS_W'(MAX_POS) && ch != 8'd0) begin
                state <= S_ADD_RD;
              end else begin
                valid_flag <= 1'b0;
                res.status <= 1'b1;
                state      <= S_OUT;
              end
            end
            REQ_ADD_LEN: begin
              if (dec || pos > POS_W'(MAX_POS)) begin
                valid_flag <= 1'b0;
                res.status <= 1'b1;
                state      <= S_OUT;
              end else if (pos == POS_W'(MAX_POS)) begin
                state <= S_OUT;
              end else begin
                state <= S_ADD_RD;
              end
            end
            REQ_BUILD: begin
              if (dec) begin
                valid_flag       <= 1'b0;
                res.status       <= 1'b1;
                res.largest_code <= pmc;
                state            <= S_OUT;
              end else begin
                if (!opt) pmc <= '0;
                total <= '0;
                ipos  <= '0;
                state <= S_B_POS;
              end
            end
            REQ_ENC_CHAR: begin
              if (pos >= POS_W'(MAX_POS)) begin
                enc_failed <= 1'b1;
                res.status <= 1'b1;
                state      <= S_OUT;
              end else begin
                state <= S_EC_RD;
              end
            end
            REQ_ENC_END: begin
              if (enc_failed || pos > POS_W'(MAX_POS)) begin
                res.status   <= 1'b1;
                res.key_null <= 1'b1;
                acc          <= '0;
                enc_failed   <= 1'b0;
                state        <= S_OUT;
              end else if (opt) begin
                ipos  <= pos;
                state <= S_EE_LRD;
              end else if (pos < longest) begin
                state <= S_EE_RD;
              end else begin
                ipos  <= pos + 1'b1;
                state <= S_EE_LRD;
              end
            end
            REQ_DECODE: begin
              ipos  <= '0;
              state <= dec ? S_D1_INIT : S_F_POS;
            end
            default: begin
              res.status <= 1'b1;
              state      <= S_OUT;
            end
          endcase
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          if (req == REQ_ADD_CHAR) begin
            if (pos + 1'b1 > longest) longest <= pos + 1'b1;
          end else if (pos > longest) begin
            longest <= pos;
          end
          state <= S_OUT;
        end
        S_B_POS: begin
          if (ipos >= longest) begin
            res.total_bits   <= total[5:0];
            res.largest_code <= pmc;
            state            <= S_OUT;
          end else begin
            cnt   <= '0;
            ibyte <= '0;
            state <= S_B_RD;
          end
        end
        S_B_RD: state <= S_B_CHK;
        S_B_CHK: begin
          if (sc_q[8] && cnt == 8'd255) begin
            valid_flag       <= 1'b0;
            res.status       <= 1'b1;
            res.largest_code <= pmc;
            state            <= S_OUT;
          end else begin
            if (sc_q[8]) cnt <= cnt + 1'b1;
            if (ibyte == BYTE_LAST) begin
              state <= S_B_END;
            end else begin
              ibyte <= ibyte + 1'b1;
              state <= S_B_RD;
            end
          end
        end
        S_B_END: begin
          pmc <= b_pmc;
          if (b_total > 7'd63) begin
            valid_flag       <= 1'b0;
            res.status       <= 1'b1;
            res.largest_code <= b_pmc;
            state            <= S_OUT;
          end else begin
            total <= b_total;
            ipos  <= ipos + 1'b1;
            state <= S_B_POS;
          end
        end
        S_EC_RD: state <= S_EC_DO;
        S_EC_DO: begin
          acc        <= (acc << wid_q) + KEY_W'(ec_cc);
          enc_failed <= enc_failed | ec_f;
          res.status <= enc_failed | ec_f;
          state      <= S_OUT;
        end
        S_EE_RD: state <= S_EE_T;
        S_EE_T: begin
          if (sc_q[7:0] == CODE_ILLEGAL) begin
            res.status   <= 1'b1;
            res.key_null <= 1'b1;
            acc          <= '0;
            enc_failed   <= 1'b0;
            state        <= S_OUT;
          end else begin
            if (wid_q != '0) acc <= (acc << wid_q) + KEY_W'(sc_q[7:0]);
            ipos  <= pos + 1'b1;
            state <= S_EE_LRD;
          end
        end
        S_EE_LRD: begin
          if (ipos >= longest) begin
            res.key_out <= acc;
            acc         <= '0;
            enc_failed  <= 1'b0;
            state       <= S_OUT;
          end else begin
            state <= S_EE_LDO;
          end
        end
        S_EE_LDO: begin
          acc   <= opt ? (acc << wid_q) + KEY_W'(w_ones) : (acc << wid_q);
          ipos  <= ipos + 1'b1;
          state <= S_EE_LRD;
        end
        S_F_POS: begin
          if (ipos >= longest) begin
            dec   <= 1'b1;
            state <= S_D1_INIT;
          end else begin
            ibyte <= '0;
            state <= S_F_ZERO;
          end
        end
        S_F_ZERO: begin
          ibyte <= ibyte + 1'b1;
          if (ibyte == BYTE_LAST) state <= S_F_RD;
        end
        S_F_RD: state <= S_F_WR;
        S_F_WR: begin
          ibyte <= ibyte + 1'b1;
          if (ibyte == BYTE_LAST) begin
            ipos  <= ipos + 1'b1;
            state <= S_F_POS;
          end else begin
            state <= S_F_RD;
          end
        end
        S_D1_INIT: begin
          len   <= longest;
          wsum  <= '0;
          shreg <= code;
          if (longest == '0) begin
            res.last_of_run <= 1'b1;
            state           <= S_OUT;
          end else begin
            ipos  <= longest - 1'b1;
            state <= S_D1_RD;
          end
        end
        S_D1_RD: state <= S_D1_CC;
        S_D1_CC: begin
          shreg <= shreg >> wid_q;
          wsum  <= wsum + REM_W'(wid_q);
          state <= S_D1_CH;
        end
        S_D1_CH: begin
          if (char_q == 8'd0) len <= ipos;
          if (ipos == '0) begin
            rem   <= wsum;
            state <= S_D2_RD;
          end else begin
            ipos  <= ipos - 1'b1;
            state <= S_D1_RD;
          end
        end
        S_D2_RD: state <= S_D2_CC;
        S_D2_CC: begin
          rem   <= d2_remn;
          state <= S_D2_CH;
        end
        S_D2_CH: begin
          res.decoded_char   <= (ipos < len) ? char_q : 8'd0;
          res.decoded_length <= len;
          res.last_of_run    <= (ipos == longest - 1'b1);
          state              <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (req == REQ_DECODE && !res.last_of_run) begin
              ipos  <= ipos + 1'b1;
              state <= S_D2_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_OUT) && out_free;

  always_comb begin
    res_out             = res;
    res_out.stats_valid = valid_flag;
  end

  // a dry-run build leaves every table untouched
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_B_CHK) || (state == S_B_END)) && (sc_we || wid_we) |-> !opt)
    else $error("table written during check-only build");

  // once decoding has begun it stays begun until reset
  assert property (@(posedge clk) disable iff (rst) !$fell(dec))
    else $error("decode_started cleared");

  // character table is only written while it is being filled
  assert property (@(posedge clk) disable iff (rst)
    char_we |-> (state == S_F_ZERO) || (state == S_F_WR))
    else $error("stray character table write");

  // decoding leaves the encode accumulator alone
  assert property (@(posedge clk) disable iff (rst)
    (state == S_D1_CC) || (state == S_D2_CC) || (state == S_F_WR) |=> $stable(acc))
    else $error("accumulator disturbed by decode");

endmodule

// ----- hdl/positional_dictionary_string_encoder.sv -----
// positional_dictionary_string_encoder: top level, joins the request sequencer
// and the result register. Depends on pdse_pkg, pdse_core, pdse_outreg.
//
// Usage
//   Requests enter on in_valid/in_stall, one transaction per request; results
//   leave on out_valid/out_stall. Add, encode and build give one result per
//   request; decode gives max(longest length, 1) results, the final one with
//   last_of_run set.
//   After reset the block sweeps its symbol/code memory once, one entry a
//   cycle, with in_stall held high throughout the sweep.
//   Add does a read-then-write pass over the symbol/code memory; encode
//   char reads the symbol/code and width memories once. Build does one
//   memory read and check per byte value at each position. Encode end does
//   one width-memory read per trailing position. The first decode fills
//   the character table first (clearing it, then writing it from the
//   symbol/code memory), then every decode does a read, code and check
//   step per position for the length scan and a read, code and check step
//   per emitted character.
//   One request is in work at a time; a new request is taken as soon as the
//   last result has moved into the output register, even while it is held.
//   A stalled receiver holds the result register and the sequencer waits in
//   its output state; nothing is lost or repeated.
module positional_dictionary_string_encoder
  import pdse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic [5:0]       position,
  input  logic [7:0]       char_value,
  input  logic             option_flag,
  input  logic [KEY_W-1:0] code_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             status,
  output logic [KEY_W-1:0] key_out,
  output logic             key_null,
  output logic [5:0]       total_bits,
  output logic [KEY_W-1:0] largest_code,
  output logic [7:0]       decoded_char,
  output logic [5:0]       decoded_length,
  output logic             last_of_run,
  output logic             stats_valid
);

  logic push;
  logic out_free;
  res_t res_core;
  res_t res_reg;

  // sequencer and the three memories
  pdse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .position    (position),
    .char_value  (char_value),
    .option_flag (option_flag),
    .code_in     (code_in),
    .out_free    (out_free),
    .push        (push),
    .res_out     (res_core)
  );

  // result register, parts the sequencer from the receiver
  pdse_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res_core),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_reg)
  );

  assign status         = res_reg.status;
  assign key_out        = res_reg.key_out;
  assign key_null       = res_reg.key_null;
  assign total_bits     = res_reg.total_bits;
  assign largest_code   = res_reg.largest_code;
  assign decoded_char   = res_reg.decoded_char;
  assign decoded_length = res_reg.decoded_length;
  assign last_of_run    = res_reg.last_of_run;
  assign stats_valid    = res_reg.stats_valid;

endmodule
